>>> sv/alurf_pkg.sv
// Shared types and constants for the register-file ALU block.
// Holds the input and output word structs, opcode and mode codes, and sizes.
// No dependencies.
package alurf_pkg;

  localparam int unsigned NUM_REGS = 12;
  localparam int unsigned RF_AW    = $clog2(NUM_REGS);

  localparam logic       REQ_ALU   = 1'b0;
  localparam logic       REQ_WRITE = 1'b1;

  localparam logic [1:0] MODE_REG  = 2'd0;
  localparam logic [1:0] MODE_IMM  = 2'd1;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_AND = 4'd4;
  localparam logic [3:0] OP_OR  = 4'd5;
  localparam logic [3:0] OP_XOR = 4'd6;
  localparam logic [3:0] OP_NOT = 4'd7;
  localparam logic [3:0] OP_SHL = 4'd8;
  localparam logic [3:0] OP_SHR = 4'd9;

  // Status flag bit positions
  localparam int unsigned FLG_Z = 0;
  localparam int unsigned FLG_C = 1;
  localparam int unsigned FLG_O = 2;
  localparam int unsigned FLG_S = 3;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  alu_op;
    logic [1:0]  operand_mode;
    logic [3:0]  dest_reg;
    logic [31:0] operand_word;
  } alurf_req_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [31:0] remainder_value;
    logic        zero_flag;
    logic        carry_flag;
    logic        overflow_flag;
    logic        sign_flag;
    logic        divide_error;
  } alurf_rsp_t;

endpackage

>>> sv/alurf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module alurf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/alu_with_register_file_and_flags.sv
// Sequence: a register write goes from idle straight to writeback; an ALU operation reads
// its two operands, executes and writes back; a divide runs 32 radix-2 steps on the shared
// adder and a remainder step before writeback (a divide by zero skips the 32 steps).
// One word at a time: the next word is taken the cycle after writeback, which waits while
// the output is stalled. The RAM's single read port makes the two operand reads sequential.
// Reset clears the sequencer, the status flags, the output valid and the register valid bits.
module alu_with_register_file_and_flags (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  alurf_pkg::alurf_req_t in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output alurf_pkg::alurf_rsp_t out_data_o
);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDA  = 3'd1;  // read first operand
  localparam logic [2:0] S_RDB  = 3'd2;  // capture first operand, read second
  localparam logic [2:0] S_EXEC = 3'd3;  // run the operation; add and sub use the shared adder
  localparam logic [2:0] S_DIV  = 3'd4;  // one restoring divide step per cycle
  localparam logic [2:0] S_REM  = 3'd5;  // write the remainder back in register mode
  localparam logic [2:0] S_WB   = 3'd6;  // write the result, load the output word

  localparam int unsigned AW = alurf_pkg::RF_AW;

  localparam logic [1:0] MODE_SEL_REG = alurf_pkg::MODE_REG;
  localparam logic [1:0] MODE_SEL_IMM = alurf_pkg::MODE_IMM;

  logic [2:0]                          state_q, state_d;
  alurf_pkg::alurf_req_t               req_q, req_d;
  logic [31:0]                         a_q, a_d;
  logic [31:0]                         b_q, b_d;
  logic [31:0]                         res_q, res_d;   // result, also quotient shifter
  logic [31:0]                         rem_q, rem_d;   // remainder accumulator
  logic                                carry_q, carry_d;
  logic                                ovf_q, ovf_d;
  logic                                derr_q, derr_d;
  logic [4:0]                          cnt_q, cnt_d;
  logic                                rd_ok_q, rd_ok_d;
  logic [3:0]                          flags_q, flags_d;
  logic [alurf_pkg::NUM_REGS-1:0]      valid_q;
  logic                                out_valid_q, out_valid_d;
  alurf_pkg::alurf_rsp_t               out_q, out_d;

  // Register file port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  // Index decode
  logic [31:0]   dest_ext;
  logic [AW-1:0] dest_idx;
  logic [AW-1:0] src_idx;
  logic          dest_ok;
  logic          src_ok;

  // Shared adder/subtractor: add, sub and every divide step
  logic [33:0]   add_x;
  logic [33:0]   add_y;
  logic          add_sub;
  logic [33:0]   add_sum;

  logic [31:0]   b_val;
  logic [63:0]   prod;
  logic          out_load;

  assign dest_ext = 32'(req_q.dest_reg);
  assign dest_idx = dest_ext[AW-1:0];
  assign src_idx  = req_q.operand_word[AW-1:0];
  assign dest_ok  = dest_ext < 32'(alurf_pkg::NUM_REGS);
  assign src_ok   = req_q.operand_word < 32'(alurf_pkg::NUM_REGS);

  // Second operand as seen in the execute cycle; out-of-range or unwritten reads give zero
  always_comb begin
    case (req_q.operand_mode)
      MODE_SEL_REG: b_val = rd_ok_q ? ram_rdata : 32'd0;
      MODE_SEL_IMM: b_val = req_q.operand_word;
      default:      b_val = 32'd0;
    endcase
  end

  always_comb begin
    if (state_q == S_DIV) begin
      add_x   = {1'b0, rem_q, res_q[31]};
      add_y   = {2'b00, b_q};
      add_sub = 1'b1;
    end else begin
      add_x   = {2'b00, a_q};
      add_y   = {2'b00, b_val};
      add_sub = (req_q.alu_op == alurf_pkg::OP_SUB);
    end
    add_sum = add_x + (add_y ^ {34{add_sub}}) + 34'(add_sub);
  end

  assign prod = {32'd0, a_q} * {32'd0, b_val};

  assign out_load = (state_q == S_WB) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    a_d         = a_q;
    b_d         = b_q;
    res_d       = res_q;
    rem_d       = rem_q;
    carry_d     = carry_q;
    ovf_d       = ovf_q;
    derr_d      = derr_q;
    cnt_d       = cnt_q;
    rd_ok_d     = rd_ok_q;
    flags_d     = flags_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = dest_idx;
    ram_wdata   = res_q;
    ram_raddr   = dest_idx;

    // Drop the output word once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = in_data_i;
          res_d = in_data_i.operand_word;
          if (in_data_i.req_type == alurf_pkg::REQ_WRITE) begin
            state_d = S_WB;
          end else begin
            state_d = S_RDA;
          end
        end
      end

      S_RDA: begin
        ram_raddr = dest_idx;
        rd_ok_d   = dest_ok && valid_q[dest_idx];
        state_d   = S_RDB;
      end

      S_RDB: begin
        a_d       = rd_ok_q ? ram_rdata : 32'd0;
        ram_raddr = src_idx;
        rd_ok_d   = src_ok && valid_q[src_idx];
        state_d   = S_EXEC;
      end

      S_EXEC: begin
        b_d     = b_val;
        rem_d   = 32'd0;
        carry_d = 1'b0;
        ovf_d   = 1'b0;
        derr_d  = 1'b0;
        state_d = S_WB;
        case (req_q.alu_op)
          alurf_pkg::OP_ADD: begin
            res_d   = add_sum[31:0];
            carry_d = add_sum[32];
            ovf_d   = ~(a_q[31] ^ b_val[31]) & (add_sum[31] ^ a_q[31]);
          end
          alurf_pkg::OP_SUB: begin
            res_d   = add_sum[31:0];
            carry_d = add_sum[33];  // borrow
            ovf_d   = (a_q[31] ^ b_val[31]) & (add_sum[31] ^ a_q[31]);
          end
          alurf_pkg::OP_MUL: begin
            res_d   = prod[31:0];
            carry_d = |prod[63:32];
            ovf_d   = |prod[63:32];
          end
          alurf_pkg::OP_DIV: begin
            if (b_val == 32'd0) begin
              res_d   = '1;
              rem_d   = a_q;
              derr_d  = 1'b1;
              state_d = S_REM;
            end else begin
              res_d   = a_q;  // dividend shifts out as quotient shifts in
              cnt_d   = 5'd0;
              state_d = S_DIV;
            end
          end
          alurf_pkg::OP_AND: res_d = a_q & b_val;
          alurf_pkg::OP_OR:  res_d = a_q | b_val;
          alurf_pkg::OP_XOR: res_d = a_q ^ b_val;
          alurf_pkg::OP_NOT: res_d = ~a_q;
          alurf_pkg::OP_SHL: res_d = (|b_val[31:5]) ? 32'd0 : (a_q << b_val[4:0]);
          alurf_pkg::OP_SHR: res_d = (|b_val[31:5]) ? 32'd0 : (a_q >> b_val[4:0]);
          default:           res_d = a_q;
        endcase
      end

      S_DIV: begin
        // Restoring step: keep the difference when no borrow
        if (!add_sum[33]) begin
          rem_d = add_sum[31:0];
          res_d = {res_q[30:0], 1'b1};
        end else begin
          rem_d = {rem_q[30:0], res_q[31]};
          res_d = {res_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = S_REM;
        end
      end

      S_REM: begin
        // Remainder goes to the source only in register mode; quotient overwrites later
        ram_we    = (req_q.operand_mode == alurf_pkg::MODE_REG) && src_ok;
        ram_waddr = src_idx;
        ram_wdata = rem_q;
        state_d   = S_WB;
      end

      S_WB: begin
        if (out_load) begin
          ram_we      = dest_ok;
          ram_waddr   = dest_idx;
          ram_wdata   = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          out_d.result_value = res_q;
          if (req_q.req_type == alurf_pkg::REQ_WRITE) begin
            out_d.remainder_value = 32'd0;
            out_d.zero_flag       = flags_q[alurf_pkg::FLG_Z];
            out_d.carry_flag      = flags_q[alurf_pkg::FLG_C];
            out_d.overflow_flag   = flags_q[alurf_pkg::FLG_O];
            out_d.sign_flag       = flags_q[alurf_pkg::FLG_S];
            out_d.divide_error    = 1'b0;
          end else begin
            flags_d[alurf_pkg::FLG_Z] = (res_q == 32'd0);
            flags_d[alurf_pkg::FLG_C] = carry_q;
            flags_d[alurf_pkg::FLG_O] = ovf_q;
            flags_d[alurf_pkg::FLG_S] = res_q[31];
            out_d.remainder_value     = rem_q;
            out_d.zero_flag           = (res_q == 32'd0);
            out_d.carry_flag          = carry_q;
            out_d.overflow_flag       = ovf_q;
            out_d.sign_flag           = res_q[31];
            out_d.divide_error        = derr_q;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      flags_q     <= 4'd0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= 5'd0;
    end else begin
      state_q     <= state_d;
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    a_q     <= a_d;
    b_q     <= b_d;
    res_q   <= res_d;
    rem_q   <= rem_d;
    carry_q <= carry_d;
    ovf_q   <= ovf_d;
    derr_q  <= derr_d;
    rd_ok_q <= rd_ok_d;
    out_q   <= out_d;
  end

  alurf_ram #(
    .WIDTH (32),
    .DEPTH (alurf_pkg::NUM_REGS)
  ) u_rf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Divider runs its full 32 steps before leaving
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q != 5'd31) |=> state_q == S_DIV)
    else $error("divider left early");

  // Divide error word carries the all-ones quotient and no carry or overflow
  a_derr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.divide_error) |->
      (out_data_o.result_value == 32'hFFFF_FFFF && !out_data_o.carry_flag &&
       !out_data_o.overflow_flag))
    else $error("bad divide-by-zero word");

  // Zero and sign can never be set together
  a_zs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(flags_q[alurf_pkg::FLG_Z] && flags_q[alurf_pkg::FLG_S]))
    else $error("zero and sign both set");

  // Register file writes only in the remainder and writeback steps
  a_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_REM || state_q == S_WB))
    else $error("stray register file write");

endmodule

>>> tb/sv/alu_with_register_file_and_flags_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for alu_with_register_file_and_flags.
// Depends on alurf_pkg for the request and response word types and the opcode codes.
// A shadow register file predicts every response word, and a checker compares them in order.
module alu_with_register_file_and_flags_tb;

  // Give up after this many cycles in which no word moves on either side.
  // The slowest correct case is a divide, plus a long receiver stall and a long sender gap.
  localparam int unsigned IDLE_LIMIT   = 1000;
  // Cycles to wait once all results are in, to catch a stray extra word.
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam int unsigned RANDOM_WORDS = 700;

  // Second operand is zero in both of these modes.
  localparam logic [1:0] MODE_ZERO_A  = 2'd2;
  localparam logic [1:0] MODE_ZERO_B  = 2'd3;
  // Opcodes with no operation: the destination keeps its value.
  localparam logic [3:0] OP_SPARE_LO  = 4'd10;
  localparam logic [3:0] OP_SPARE_HI  = 4'd15;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_style_e;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  alurf_pkg::alurf_req_t in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  alurf_pkg::alurf_rsp_t out_data_o;

  alu_with_register_file_and_flags u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow state and response prediction
  // ---------------------------------------------------------------------------
  logic [31:0]           rf_shadow [alurf_pkg::NUM_REGS];
  logic [3:0]            flags_shadow;
  alurf_pkg::alurf_rsp_t pending_results [$];

  int unsigned words_sent     = 0;
  int unsigned words_checked  = 0;
  int unsigned mismatch_count = 0;
  int unsigned write_count    = 0;
  int unsigned div_count      = 0;
  int unsigned div_zero_count = 0;
  int unsigned oob_count      = 0;

  initial begin
    foreach (rf_shadow[i]) rf_shadow[i] = '0;
    flags_shadow = '0;
  end

  // An index at or past the register count reads as zero and drops writes.
  function automatic logic [31:0] shadow_read(logic [31:0] idx);
    if (idx < alurf_pkg::NUM_REGS) return rf_shadow[idx];
    return '0;
  endfunction

  function automatic void shadow_write(logic [31:0] idx, logic [31:0] value);
    if (idx < alurf_pkg::NUM_REGS) rf_shadow[idx] = value;
  endfunction

  // Work out the response word for one request and advance the shadow state.
  function automatic alurf_pkg::alurf_rsp_t compute_alu_word(alurf_pkg::alurf_req_t w);
    alurf_pkg::alurf_rsp_t r;
    logic [31:0] a, b, res, rem;
    logic [63:0] prod;
    logic [3:0]  fl;
    logic        derr;
    r    = '0;
    rem  = '0;
    fl   = '0;
    derr = 1'b0;
    if (w.req_type == alurf_pkg::REQ_WRITE) begin
      // A register write reports the flags as they stand and leaves them alone.
      shadow_write({28'd0, w.dest_reg}, w.operand_word);
      r.result_value  = w.operand_word;
      r.zero_flag     = flags_shadow[alurf_pkg::FLG_Z];
      r.carry_flag    = flags_shadow[alurf_pkg::FLG_C];
      r.overflow_flag = flags_shadow[alurf_pkg::FLG_O];
      r.sign_flag     = flags_shadow[alurf_pkg::FLG_S];
      return r;
    end
    a = shadow_read({28'd0, w.dest_reg});
    case (w.operand_mode)
      alurf_pkg::MODE_REG: b = shadow_read(w.operand_word);
      alurf_pkg::MODE_IMM: b = w.operand_word;
      default:             b = '0;
    endcase
    case (w.alu_op)
      alurf_pkg::OP_ADD: begin
        res                 = a + b;
        fl[alurf_pkg::FLG_C] = res < a;
        fl[alurf_pkg::FLG_O] = (a[31] == b[31]) && (res[31] != a[31]);
      end
      alurf_pkg::OP_SUB: begin
        res                 = a - b;
        fl[alurf_pkg::FLG_C] = a < b;
        fl[alurf_pkg::FLG_O] = (a[31] != b[31]) && (res[31] != a[31]);
      end
      alurf_pkg::OP_MUL: begin
        prod                = 64'(a) * 64'(b);
        fl[alurf_pkg::FLG_C] = |prod[63:32];
        fl[alurf_pkg::FLG_O] = |prod[63:32];
        res                 = prod[31:0];
      end
      alurf_pkg::OP_DIV: begin
        if (b == '0) begin
          res  = '1;
          rem  = a;
          derr = 1'b1;
        end else begin
          res = a / b;
          rem = a % b;
        end
        // Remainder goes back only in register mode; the quotient write below
        // wins when source and destination are the same register.
        if (w.operand_mode == alurf_pkg::MODE_REG) shadow_write(w.operand_word, rem);
      end
      alurf_pkg::OP_AND: res = a & b;
      alurf_pkg::OP_OR:  res = a | b;
      alurf_pkg::OP_XOR: res = a ^ b;
      alurf_pkg::OP_NOT: res = ~a;
      alurf_pkg::OP_SHL: res = (b >= 32) ? '0 : (a << b);
      alurf_pkg::OP_SHR: res = (b >= 32) ? '0 : (a >> b);
      default: res = a;
    endcase
    shadow_write({28'd0, w.dest_reg}, res);
    fl[alurf_pkg::FLG_Z] = (res == '0);
    fl[alurf_pkg::FLG_S] = res[31];
    flags_shadow         = fl;

    r.result_value    = res;
    r.remainder_value = rem;
    r.zero_flag       = fl[alurf_pkg::FLG_Z];
    r.carry_flag      = fl[alurf_pkg::FLG_C];
    r.overflow_flag   = fl[alurf_pkg::FLG_O];
    r.sign_flag       = fl[alurf_pkg::FLG_S];
    r.divide_error    = derr;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Response checker
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("[%0t] result %0d: %s is %08h, predicted %08h",
             $time, words_checked, what, got, want);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Compare every accepted response word against the oldest prediction.
  always @(posedge clk_i) begin
    alurf_pkg::alurf_rsp_t want_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, result_value", out_data_o.result_value, '0);
      end else begin
        want_w = pending_results.pop_front();
        check_field("result_value", out_data_o.result_value, want_w.result_value);
        check_field("remainder_value", out_data_o.remainder_value, want_w.remainder_value);
        check_field("zero_flag", 32'(out_data_o.zero_flag), 32'(want_w.zero_flag));
        check_field("carry_flag", 32'(out_data_o.carry_flag), 32'(want_w.carry_flag));
        check_field("overflow_flag", 32'(out_data_o.overflow_flag),
                    32'(want_w.overflow_flag));
        check_field("sign_flag", 32'(out_data_o.sign_flag), 32'(want_w.sign_flag));
        check_field("divide_error", 32'(out_data_o.divide_error), 32'(want_w.divide_error));
      end
      words_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if nothing moves for too long
  // ---------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("alu_with_register_file_and_flags_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall pattern
  // ---------------------------------------------------------------------------
  stall_style_e stall_style = STALL_NONE;
  int unsigned  stall_hold  = 0;
  int unsigned  stall_phase = 0;

  // The periodic stall pattern runs out of step with the block's operations, so the stall
  // windows slide across every phase of the block's work.
  always @(posedge clk_i) begin
    stall_phase <= (stall_phase + 1) % 7;
    case (stall_style)
      STALL_NONE:     out_stall_i <= 1'b0;
      STALL_RANDOM:   out_stall_i <= ($urandom_range(99) < 35);
      STALL_PERIODIC: out_stall_i <= (stall_phase < 3);
      default: begin
        // Toggle between long stretches of stall and of no stall.
        if (stall_hold == 0) begin
          out_stall_i <= ~out_stall_i;
          stall_hold = $urandom_range(24, 1);
        end else begin
          stall_hold--;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  bit          sender_gaps = 1'b1;
  int unsigned burst_left  = 0;

  // Present one word, hold it until accepted, then record its prediction.
  // Keep valid high when the burst goes on or gaps are off; otherwise drop it for a gap.
  task automatic issue_word(alurf_pkg::alurf_req_t w);
    alurf_pkg::alurf_rsp_t want_w;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    want_w = compute_alu_word(w);
    pending_results.push_back(want_w);
    words_sent++;
    if (w.req_type == alurf_pkg::REQ_WRITE) write_count++;
    else if (w.alu_op == alurf_pkg::OP_DIV) div_count++;
    if (want_w.divide_error) div_zero_count++;
    if (w.dest_reg >= alurf_pkg::NUM_REGS) oob_count++;
    if (sender_gaps) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        // Mostly short gaps, now and then one long enough to span a divide.
        repeat (($urandom_range(99) < 10) ? $urandom_range(45, 9) : $urandom_range(8, 1))
          @(posedge clk_i);
        burst_left = $urandom_range(12);
      end else begin
        burst_left--;
      end
    end
  endtask

  function automatic alurf_pkg::alurf_req_t make_word(logic req, logic [3:0] op,
                                                      logic [1:0] mode, logic [3:0] dst,
                                                      logic [31:0] word);
    alurf_pkg::alurf_req_t w;
    w.req_type     = req;
    w.alu_op       = op;
    w.operand_mode = mode;
    w.dest_reg     = dst;
    w.operand_word = word;
    return w;
  endfunction

  task automatic load_reg(logic [3:0] dst, logic [31:0] value);
    issue_word(make_word(alurf_pkg::REQ_WRITE, alurf_pkg::OP_ADD, alurf_pkg::MODE_IMM,
                         dst, value));
  endtask

  task automatic run_op(logic [3:0] op, logic [1:0] mode, logic [3:0] dst, logic [31:0] word);
    issue_word(make_word(alurf_pkg::REQ_ALU, op, mode, dst, word));
  endtask

  // Hold off the sender until every predicted result has come back.
  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Read a register straight after reset, then load edge values; the write to
  // register 15 is out of range and must be dropped.
  task automatic test_reset_and_write();
    run_op(alurf_pkg::OP_ADD, alurf_pkg::MODE_IMM, 4'd5, 32'd0);
    load_reg(4'd1, 32'hFFFF_FFFF);
    load_reg(4'd2, 32'h8000_0000);
    load_reg(4'd3, 32'h7FFF_FFFF);
    load_reg(4'd15, 32'hDEAD_BEEF);
  endtask

  // Carry out, signed overflow and borrow on both sides of the sign boundary.
  task automatic test_add_sub_flags();
    run_op(alurf_pkg::OP_ADD, alurf_pkg::MODE_IMM, 4'd1, 32'd1);  // all ones + 1: zero, carry
    run_op(alurf_pkg::OP_ADD, alurf_pkg::MODE_IMM, 4'd3, 32'd1);  // max positive + 1: overflow
    run_op(alurf_pkg::OP_SUB, alurf_pkg::MODE_IMM, 4'd1, 32'd1);  // 0 - 1: borrow, sign
    run_op(alurf_pkg::OP_SUB, alurf_pkg::MODE_IMM, 4'd3, 32'd1);  // min negative - 1: overflow
    run_op(alurf_pkg::OP_ADD, alurf_pkg::MODE_REG, 4'd2, 32'd2);  // min negative doubled
  endtask

  task automatic test_multiply();
    run_op(alurf_pkg::OP_MUL, alurf_pkg::MODE_REG, 4'd1, 32'd1);  // all ones squared: overflow
    run_op(alurf_pkg::OP_MUL, alurf_pkg::MODE_IMM, 4'd3, 32'd2);  // fits in 32 bits
  endtask

  // Divide by zero, remainder writeback, source equal to destination, and
  // the modes in which the remainder is not written.
  task automatic test_divide();
    run_op(alurf_pkg::OP_DIV, alurf_pkg::MODE_REG, 4'd3, 32'd5);
    load_reg(4'd6, 32'd7);
    run_op(alurf_pkg::OP_DIV, alurf_pkg::MODE_REG, 4'd3, 32'd6);
    run_op(alurf_pkg::OP_DIV, alurf_pkg::MODE_REG, 4'd5, 32'd5);
    run_op(alurf_pkg::OP_DIV, alurf_pkg::MODE_IMM, 4'd3, 32'd10);
    run_op(alurf_pkg::OP_DIV, MODE_ZERO_A, 4'd3, 32'd4);
  endtask

  task automatic test_logic_and_shift();
    run_op(alurf_pkg::OP_AND, alurf_pkg::MODE_IMM, 4'd3, 32'h0F0F_0F0F);
    run_op(alurf_pkg::OP_XOR, alurf_pkg::MODE_REG, 4'd3, 32'd3);   // with itself: zero
    run_op(alurf_pkg::OP_NOT, MODE_ZERO_B, 4'd3, 32'd0);
    run_op(alurf_pkg::OP_SHL, alurf_pkg::MODE_IMM, 4'd1, 32'd31);
    run_op(alurf_pkg::OP_SHR, alurf_pkg::MODE_IMM, 4'd1, 32'd31);
    run_op(alurf_pkg::OP_SHL, alurf_pkg::MODE_IMM, 4'd1, 32'd32);  // count of 32 gives zero
    run_op(alurf_pkg::OP_SHR, alurf_pkg::MODE_IMM, 4'd3, 32'hFFFF_FFFF);
  endtask

  // Destination and source indexes past the register file read as zero.
  task automatic test_index_range();
    run_op(alurf_pkg::OP_ADD, alurf_pkg::MODE_IMM, 4'd13, 32'd5);
    run_op(alurf_pkg::OP_OR, alurf_pkg::MODE_REG, 4'd6, 32'hFFFF_FFFF);
    run_op(alurf_pkg::OP_DIV, alurf_pkg::MODE_REG, 4'd14, 32'd12);
  endtask

  task automatic test_spare_opcodes();
    run_op(OP_SPARE_LO, alurf_pkg::MODE_REG, 4'd6, 32'd0);
    run_op(OP_SPARE_HI, alurf_pkg::MODE_IMM, 4'd2, 32'd9);
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'($urandom_range(40));
      default: return $urandom;
    endcase
  endfunction

  function automatic alurf_pkg::alurf_req_t random_word();
    alurf_pkg::alurf_req_t w;
    int unsigned           sel;
    w.req_type = ($urandom_range(99) < 20) ? alurf_pkg::REQ_WRITE : alurf_pkg::REQ_ALU;
    w.alu_op   = ($urandom_range(9) == 0)
                 ? 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO))
                 : 4'($urandom_range(alurf_pkg::OP_SHR, alurf_pkg::OP_ADD));
    sel = $urandom_range(9);
    if (sel < 4)       w.operand_mode = alurf_pkg::MODE_REG;
    else if (sel < 8)  w.operand_mode = alurf_pkg::MODE_IMM;
    else if (sel == 8) w.operand_mode = MODE_ZERO_A;
    else               w.operand_mode = MODE_ZERO_B;
    w.dest_reg = ($urandom_range(19) == 0) ? 4'($urandom_range(15, alurf_pkg::NUM_REGS))
                                           : 4'($urandom_range(alurf_pkg::NUM_REGS - 1));
    if (w.req_type == alurf_pkg::REQ_ALU && w.operand_mode == alurf_pkg::MODE_REG) begin
      // Source index: mostly a real register, sometimes just past the end or wild.
      sel = $urandom_range(19);
      if (sel < 17)      w.operand_word = $urandom_range(alurf_pkg::NUM_REGS - 1);
      else if (sel < 19) w.operand_word = $urandom_range(15, alurf_pkg::NUM_REGS);
      else               w.operand_word = $urandom;
    end else begin
      w.operand_word = pick_value();
    end
    return w;
  endfunction

  // Seven phases that cycle through the four stall styles, with sender gaps off in
  // phases 3 and 6; drain fully once in the middle.
  task automatic test_random_mix();
    for (int phase = 0; phase < 7; phase++) begin
      case (phase % 4)
        0:       stall_style = STALL_RANDOM;
        1:       stall_style = STALL_PERIODIC;
        2:       stall_style = STALL_LONG;
        default: stall_style = STALL_NONE;
      endcase
      sender_gaps = (phase != 3) && (phase != 6);
      for (int n = 0; n < RANDOM_WORDS / 7; n++) issue_word(random_word());
      if (phase == 3) pause_until_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    stall_style = STALL_RANDOM;
    test_reset_and_write();
    test_add_sub_flags();
    test_multiply();
    stall_style = STALL_LONG;
    test_divide();
    test_logic_and_shift();
    pause_until_drained();
    stall_style = STALL_PERIODIC;
    test_index_range();
    test_spare_opcodes();
    test_random_mix();

    // Drop valid, let every result come back, then watch for strays.
    in_valid_i  <= 1'b0;
    stall_style = STALL_NONE;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d words (%0d register writes, %0d divides, %0d by zero, %0d out of range)",
             words_sent, write_count, div_count, div_zero_count, oob_count);
    $display("checked %0d results, %0d mismatches", words_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("alu_with_register_file_and_flags_tb: PASS");
    end else begin
      $display("alu_with_register_file_and_flags_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
sv/alurf_pkg.sv
sv/alurf_ram.sv
sv/alu_with_register_file_and_flags.sv
tb/sv/alu_with_register_file_and_flags_tb.sv
